@@ hdl/abi_pkg.sv @@
// ----------------------------------------------------------------------------
// Adams-Bashforth integrator package
// Widths, register indexes, multistep weights and divisor tables shared by
// the integrator datapath.
// ----------------------------------------------------------------------------
package abi_pkg;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 12;
    localparam int STEP_W     = 24;
    localparam int ORDER_W    = 3;
    localparam int CFG_ADDR_W = 1;

    localparam int ELEM_COUNT  = 4096;
    localparam int ADDR_W      = $clog2(ELEM_COUNT);
    localparam int HIST_DEPTH  = 5;
    localparam int LANES       = HIST_DEPTH + 1;
    localparam int LANE_W      = $clog2(LANES);
    localparam int WGT_W       = 15;
    localparam int PROD_W      = 48;
    localparam int RECIP_W     = 37;
    localparam int XW          = 38;

    localparam logic [IDX_W:0] ELEM_LIMIT = (IDX_W + 1)'(ELEM_COUNT);

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_METHOD_ORDER = 1'b1;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd65;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;
    localparam logic [ORDER_W-1:0] SWEEP_MAX   = 3'd7;
    localparam logic [ORDER_W-1:0] ORDER_MIN   = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_MAX   = ORDER_W'(LANES);

    // denominator = 2^(order-1) * odd factor
    localparam logic [1:0] DIV_ONE        = 2'd0;
    localparam logic [1:0] DIV_THREE      = 2'd1;
    localparam logic [1:0] DIV_FORTY_FIVE = 2'd2;

    // floor(2^XW / factor)
    localparam logic [RECIP_W-1:0] RECIP_THREE      = 37'd91625968981;
    localparam logic [RECIP_W-1:0] RECIP_FORTY_FIVE = 37'd6108397932;

    typedef logic [HIST_DEPTH-1:0][DATA_W-1:0] row_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  pos;
        logic               last;
        logic [ORDER_W-1:0] order;
    } side_t;

    function automatic logic signed [WGT_W-1:0] ab_weight(
        input logic [ORDER_W-1:0] order,
        input logic [LANE_W-1:0]  lane
    );
        logic signed [WGT_W-1:0] w;
        w = '0;
        case (order)
            3'd1: begin
                case (lane)
                    3'd0:    w = 15'sd1;
                    default: w = '0;
                endcase
            end
            3'd2: begin
                case (lane)
                    3'd0:    w = 15'sd3;
                    3'd1:    w = -15'sd1;
                    default: w = '0;
                endcase
            end
            3'd3: begin
                case (lane)
                    3'd0:    w = 15'sd23;
                    3'd1:    w = -15'sd16;
                    3'd2:    w = 15'sd5;
                    default: w = '0;
                endcase
            end
            3'd4: begin
                case (lane)
                    3'd0:    w = 15'sd55;
                    3'd1:    w = -15'sd59;
                    3'd2:    w = 15'sd37;
                    3'd3:    w = -15'sd9;
                    default: w = '0;
                endcase
            end
            3'd5: begin
                case (lane)
                    3'd0:    w = 15'sd1901;
                    3'd1:    w = -15'sd2774;
                    3'd2:    w = 15'sd2616;
                    3'd3:    w = -15'sd1274;
                    3'd4:    w = 15'sd251;
                    default: w = '0;
                endcase
            end
            3'd6: begin
                case (lane)
                    3'd0:    w = 15'sd4277;
                    3'd1:    w = -15'sd7923;
                    3'd2:    w = 15'sd9982;
                    3'd3:    w = -15'sd7298;
                    3'd4:    w = 15'sd2877;
                    3'd5:    w = -15'sd475;
                    default: w = '0;
                endcase
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] den_div(input logic [ORDER_W-1:0] order);
        logic [1:0] code;
        case (order)
            3'd3, 3'd4: code = DIV_THREE;
            3'd5, 3'd6: code = DIV_FORTY_FIVE;
            default:    code = DIV_ONE;
        endcase
        return code;
    endfunction

    function automatic logic [RECIP_W-1:0] den_recip(input logic [1:0] code);
        logic [RECIP_W-1:0] m;
        case (code)
            DIV_THREE:      m = RECIP_THREE;
            DIV_FORTY_FIVE: m = RECIP_FORTY_FIVE;
            default:        m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/adams_bashforth_integrator.sv @@
// ----------------------------------------------------------------------------
// Adams-Bashforth integrator, orders 1 to 6
// Updates one Q16.16 state element per request from its new derivative and
// its stored derivative history, scaled by dt, saturated.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                    | tuser    | tlast
//  s_       | in        | elem_index, position_in, deriv_in, pad | -        | last_of_sweep
//  m_       | out       | elem_index_out, position_out, pad      | overflow | sweep_done
//  cfg_     | in        | cfg_addr 0 step_size, 1 method_order (write only)
//
//  One request per cycle while m_tready does not stall the pipeline; each
//  request passes through eleven register stages to m_tvalid. The history
//  row is read at acceptance and written when the item leaves stage 0, with
//  a forward path for back-to-back requests on one element.
//  Reset (aresetn low, synchronous) clears the pipeline and the sweep counter
//  and restores dt and order; the history memory is not cleared.
//  A stall on m_tready stops only occupied stages; empty stages still fill.
// ----------------------------------------------------------------------------
module adams_bashforth_integrator import abi_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [STEP_W-1:0]     cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,   // elem_index, position_in, derivative_in, pad
    input  logic                  s_tlast,   // last_of_sweep

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // elem_index_out, position_out, pad
    output logic                  m_tuser,   // overflow
    output logic                  m_tlast    // sweep_done
);

    localparam int NSTG = 11;

    logic [STEP_W-1:0]  step_reg;
    logic [ORDER_W-1:0] order_cfg_reg;
    logic [ORDER_W-1:0] sweep_reg;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;
    logic            accept;

    logic [IDX_W-1:0]  in_idx;
    logic [DATA_W-1:0] in_pos;
    logic [DATA_W-1:0] in_der;

    logic [ORDER_W-1:0] ord_lim;
    logic [ORDER_W:0]   sweep_cap;

    side_t             side_reg [NSTG-1];
    logic [DATA_W-1:0] der0_reg;
    row_t              rd_row_reg;
    row_t              fwd_row_reg;
    logic              fwd_hit_reg;
    row_t              hist_mem [ELEM_COUNT];

    logic              rng0;
    logic              hist_we;
    row_t              hist_row;
    row_t              new_row;
    logic signed [DATA_W-1:0] lane_d [LANES];
    logic signed [PROD_W-1:0] prod_next [LANES];
    logic signed [PROD_W-1:0] prod_reg  [LANES];
    logic signed [PROD_W-1:0] pair_next [LANES/2];
    logic signed [PROD_W-1:0] pair_reg  [LANES/2];
    logic signed [PROD_W-1:0] sum_next;
    logic signed [PROD_W-1:0] sum_reg;

    logic [PROD_W-1:0] mag_next;
    logic [PROD_W-1:0] mag_reg;
    logic [NSTG-2:4]   neg_pipe_reg;
    logic [2*STEP_W-1:0] ph_next, pl_next, ph_reg, pl_reg;

    logic [2*STEP_W+STEP_W-1:0] scaled;
    logic [2*STEP_W+STEP_W-17:0] x_wide;
    logic [XW-1:0]     x_next, x6_reg, x7_reg, x8_reg;
    logic              big_next;
    logic [NSTG-2:6]   big_pipe_reg;

    logic [RECIP_W-1:0] recip;
    logic [XW-1:0]      hh_next, hl_next, lh_next, ll_next;
    logic [XW-1:0]      hh_reg, hl_reg, lh_reg, ll_reg;
    logic [XW+1:0]      mid;
    logic [XW-1:0]      qest_next, qest_reg;

    logic [1:0]         div9;
    logic [XW+5:0]      qb;
    logic [XW+5:0]      rem;
    logic [XW-1:0]      quo_next, quo_reg;

    logic [DATA_W+7:0]  pos_ext;
    logic [DATA_W+7:0]  sum40;
    logic [DATA_W-1:0]  res_next;
    logic               ovf_next;

    logic [IDX_W-1:0]   out_idx_reg;
    logic [DATA_W-1:0]  out_pos_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_pos = s_tdata[IDX_W+DATA_W-1:IDX_W];
    assign in_der = s_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];

    always_comb begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign accept   = s_tvalid && rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_RESET;
            order_cfg_reg <= ORDER_RESET;
            sweep_reg     <= '0;
        end else begin
            if (cfg_we && cfg_addr == REG_STEP_SIZE) begin
                step_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == REG_METHOD_ORDER) begin
                order_cfg_reg <= cfg_wdata[ORDER_W-1:0];
                sweep_reg     <= '0;
            end else if (accept && s_tlast && sweep_reg != SWEEP_MAX) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
        end
    end

    always_comb begin
        ord_lim = order_cfg_reg;
        if (ord_lim < ORDER_MIN) begin
            ord_lim = ORDER_MIN;
        end
        if (ord_lim > ORDER_MAX) begin
            ord_lim = ORDER_MAX;
        end
        sweep_cap = {1'b0, sweep_reg} + 1'b1;
        if (sweep_cap < {1'b0, ord_lim}) begin
            ord_lim = sweep_cap[ORDER_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // history row: read at acceptance, written when the item leaves stage 0
    assign rng0    = {1'b0, side_reg[0].idx} < ELEM_LIMIT;
    assign hist_we = vld_reg[0] && rdy[1] && rng0;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            rd_row_reg <= hist_mem[in_idx[ADDR_W-1:0]];
        end
        if (hist_we) begin
            hist_mem[side_reg[0].idx[ADDR_W-1:0]] <= new_row;
        end
    end

    always_comb begin
        hist_row = rng0 ? (fwd_hit_reg ? fwd_row_reg : rd_row_reg) : '0;
        new_row[0] = der0_reg;
        for (int j = 1; j < HIST_DEPTH; j++) begin
            new_row[j] = hist_row[j-1];
        end
        lane_d[0] = der0_reg;
        // drop lanes above the order in use
        for (int k = 1; k < LANES; k++) begin
            lane_d[k] = (LANE_W'(k) < side_reg[0].order) ? hist_row[k-1] : '0;
        end
        for (int k = 0; k < LANES; k++) begin
            prod_next[k] = lane_d[k] * ab_weight(side_reg[0].order, LANE_W'(k));
        end
        for (int j = 0; j < LANES / 2; j++) begin
            pair_next[j] = prod_reg[2*j] + prod_reg[2*j+1];
        end
        sum_next = '0;
        for (int j = 0; j < LANES / 2; j++) begin
            sum_next = sum_next + pair_reg[j];
        end
        mag_next = sum_reg[PROD_W-1] ? PROD_W'(-sum_reg) : PROD_W'(sum_reg);
    end

    assign ph_next = mag_reg[2*STEP_W-1:STEP_W] * step_reg;
    assign pl_next = mag_reg[STEP_W-1:0] * step_reg;

    // divide by 2^(16 + order - 1); the odd factor follows
    always_comb begin
        scaled   = {ph_reg, {STEP_W{1'b0}}} + {{STEP_W{1'b0}}, pl_reg};
        x_wide   = scaled[$bits(scaled)-1:16] >> (side_reg[5].order - 1'b1);
        big_next = |x_wide[$bits(x_wide)-1:XW];
        x_next   = x_wide[XW-1:0];
    end

    // reciprocal multiply in four partial products
    always_comb begin
        recip   = den_recip(den_div(side_reg[6].order));
        hh_next = XW'(x6_reg[XW-1:19] * recip[RECIP_W-1:19]);
        hl_next = XW'(x6_reg[XW-1:19] * recip[18:0]);
        lh_next = XW'(x6_reg[18:0] * recip[RECIP_W-1:19]);
        ll_next = XW'(x6_reg[18:0] * recip[18:0]);
        mid       = {2'b0, hl_reg} + {2'b0, lh_reg} + {21'b0, ll_reg[XW-1:19]};
        qest_next = hh_reg + XW'(mid[XW+1:19]);
    end

    // one correction step of the reciprocal estimate
    always_comb begin
        div9 = den_div(side_reg[8].order);
        case (div9)
            DIV_THREE:      qb = ({6'b0, qest_reg} << 1) + {6'b0, qest_reg};
            DIV_FORTY_FIVE: qb = ({6'b0, qest_reg} << 5) + ({6'b0, qest_reg} << 3)
                               + ({6'b0, qest_reg} << 2) + {6'b0, qest_reg};
            default:        qb = '0;
        endcase
        rem = {6'b0, x8_reg} - qb;
        case (div9)
            DIV_THREE:      quo_next = qest_reg + XW'(rem >= (XW+6)'(3));
            DIV_FORTY_FIVE: quo_next = qest_reg + XW'(rem >= (XW+6)'(45));
            default:        quo_next = x8_reg;
        endcase
    end

    // add and saturate
    always_comb begin
        pos_ext = {{8{side_reg[9].pos[DATA_W-1]}}, side_reg[9].pos};
        if (neg_pipe_reg[9]) begin
            sum40 = pos_ext - {2'b0, quo_reg};
        end else begin
            sum40 = pos_ext + {2'b0, quo_reg};
        end
        ovf_next = 1'b0;
        res_next = sum40[DATA_W-1:0];
        if (big_pipe_reg[9]) begin
            ovf_next = 1'b1;
            res_next = neg_pipe_reg[9] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}};
        end else if (sum40[DATA_W+7:DATA_W-1] != {9{sum40[DATA_W+7]}}) begin
            ovf_next = 1'b1;
            res_next = sum40[DATA_W+7] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            side_reg[0].idx   <= in_idx;
            side_reg[0].pos   <= in_pos;
            side_reg[0].last  <= s_tlast;
            side_reg[0].order <= ord_lim;
            der0_reg          <= in_der;
            fwd_hit_reg       <= vld_reg[0] && rng0 && (side_reg[0].idx == in_idx);
            fwd_row_reg       <= new_row;
        end
        for (int i = 1; i < NSTG - 1; i++) begin
            if (rdy[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
        if (rdy[1]) begin
            prod_reg <= prod_next;
        end
        if (rdy[2]) begin
            pair_reg <= pair_next;
        end
        if (rdy[3]) begin
            sum_reg <= sum_next;
        end
        if (rdy[4]) begin
            mag_reg         <= mag_next;
            neg_pipe_reg[4] <= sum_reg[PROD_W-1];
        end
        if (rdy[5]) begin
            ph_reg          <= ph_next;
            pl_reg          <= pl_next;
            neg_pipe_reg[5] <= neg_pipe_reg[4];
        end
        if (rdy[6]) begin
            x6_reg          <= x_next;
            big_pipe_reg[6] <= big_next;
            neg_pipe_reg[6] <= neg_pipe_reg[5];
        end
        if (rdy[7]) begin
            hh_reg          <= hh_next;
            hl_reg          <= hl_next;
            lh_reg          <= lh_next;
            ll_reg          <= ll_next;
            x7_reg          <= x6_reg;
            big_pipe_reg[7] <= big_pipe_reg[6];
            neg_pipe_reg[7] <= neg_pipe_reg[6];
        end
        if (rdy[8]) begin
            qest_reg        <= qest_next;
            x8_reg          <= x7_reg;
            big_pipe_reg[8] <= big_pipe_reg[7];
            neg_pipe_reg[8] <= neg_pipe_reg[7];
        end
        if (rdy[9]) begin
            quo_reg         <= quo_next;
            big_pipe_reg[9] <= big_pipe_reg[8];
            neg_pipe_reg[9] <= neg_pipe_reg[8];
        end
        if (rdy[10]) begin
            out_idx_reg  <= side_reg[9].idx;
            out_pos_reg  <= res_next;
            out_ovf_reg  <= ovf_next;
            out_last_reg <= side_reg[9].last;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {4'b0, out_pos_reg, out_idx_reg};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ verif/adams_bashforth_integrator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adams-Bashforth integrator testbench
// Streams element updates through the integrator with random bursts of idle
// cycles on both sides, and rewrites dt and the method order between phases.
// A local copy of the derivative history and sweep counter predicts each
// result, which the monitor compares field by field in order of arrival.
// ----------------------------------------------------------------------------
module adams_bashforth_integrator_tb;
    import abi_pkg::*;

    localparam int RAND_ITEMS = 1600;
    localparam int DRAIN_WAIT = 30;
    localparam int POOL_SIZE  = 32;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] deriv;
        logic                     last;
    } elem_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] pos;
        logic                     ovf;
        logic                     done;
    } elem_res_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [STEP_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [47:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    adams_bashforth_integrator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // integrator copy: dt, order, sweep counter, derivative history
    logic [STEP_W-1:0]        dt_q;
    logic [ORDER_W-1:0]       order_q;
    logic [ORDER_W-1:0]       sweeps_q;
    logic signed [DATA_W-1:0] deriv_hist [ELEM_COUNT][HIST_DEPTH];

    // stimulus bookkeeping: writes seen per element, order and sweeps at queue time
    int                 gen_depth [ELEM_COUNT];
    logic [ORDER_W-1:0] gen_order;
    logic [ORDER_W-1:0] gen_sweeps;
    int                 last_idx;
    int                 elem_pool [POOL_SIZE];

    elem_req_t req_pend_q [$];
    elem_res_t pos_expect_q [$];
    elem_req_t drv_req;
    int        src_gap  = 0;
    int        sink_gap = 0;
    int        fail_cnt = 0;
    bit        quiet    = 1'b0;

    function automatic logic [5:0][15:0] ab_coef_row(input int p);
        case (p)
            1:       return {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
            2:       return {16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd3};
            3:       return {16'sd0, 16'sd0, 16'sd0, 16'sd5, -16'sd16, 16'sd23};
            4:       return {16'sd0, 16'sd0, -16'sd9, 16'sd37, -16'sd59, 16'sd55};
            5:       return {16'sd0, 16'sd251, -16'sd1274, 16'sd2616, -16'sd2774,
                             16'sd1901};
            default: return {-16'sd475, 16'sd2877, -16'sd7298, 16'sd9982, -16'sd7923,
                             16'sd4277};
        endcase
    endfunction

    function automatic longint unsigned ab_denom(input int p);
        case (p)
            1:       return 1;
            2:       return 2;
            3:       return 12;
            4:       return 24;
            5:       return 720;
            default: return 1440;
        endcase
    endfunction

    function automatic int clamp_order(input logic [ORDER_W-1:0] mo,
                                       input logic [ORDER_W-1:0] sw);
        int p;
        p = mo;
        if (p < 1) p = 1;
        if (p > HIST_DEPTH + 1) p = HIST_DEPTH + 1;
        if (p > sw + 1) p = sw + 1;
        return p;
    endfunction

    // advance one element: weighted sum, scale by dt, saturate, shift history
    function automatic elem_res_t integrate_elem(input elem_req_t r);
        elem_res_t         o;
        logic [5:0][15:0]  coef;
        longint            acc;
        longint            sum;
        longint unsigned   mag;
        longint unsigned   den;
        longint unsigned   q;
        int                p;
        p    = clamp_order(order_q, sweeps_q);
        coef = ab_coef_row(p);
        acc  = 0;
        for (int k = 0; k < p; k++) begin
            if (k == 0)
                acc += longint'($signed(coef[k])) * longint'(r.deriv);
            else
                acc += longint'($signed(coef[k])) * longint'(deriv_hist[r.idx][k-1]);
        end
        mag = (acc < 0) ? longint'(-acc) : longint'(acc);
        den = ab_denom(p) * 64'd65536;
        q   = (mag / den) * longint'(dt_q) + ((mag % den) * longint'(dt_q)) / den;
        sum = longint'(r.pos) + ((acc < 0) ? -longint'(q) : longint'(q));
        o.idx  = r.idx;
        o.done = r.last;
        o.ovf  = 1'b0;
        if (sum > longint'(Q_MAX)) begin
            sum   = longint'(Q_MAX);
            o.ovf = 1'b1;
        end else if (sum < longint'(Q_MIN)) begin
            sum   = longint'(Q_MIN);
            o.ovf = 1'b1;
        end
        o.pos = sum[DATA_W-1:0];
        for (int j = HIST_DEPTH - 1; j > 0; j--)
            deriv_hist[r.idx][j] = deriv_hist[r.idx][j-1];
        deriv_hist[r.idx][0] = r.deriv;
        if (r.last && sweeps_q != SWEEP_MAX)
            sweeps_q++;
        return o;
    endfunction

    function automatic void push_req(input int idx, input logic [DATA_W-1:0] pos,
                                     input logic [DATA_W-1:0] deriv, input bit last);
        elem_req_t r;
        r.idx   = IDX_W'(idx);
        r.pos   = pos;
        r.deriv = deriv;
        r.last  = last;
        req_pend_q.push_back(r);
        if (gen_depth[idx] < HIST_DEPTH)
            gen_depth[idx]++;
        if (last && gen_sweeps != SWEEP_MAX)
            gen_sweeps++;
        last_idx = idx;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        logic [DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return {{16{r[15]}}, r[15:0]};
            4:       return {{30{r[1]}}, r[1:0]};
            default: return r;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [STEP_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == REG_STEP_SIZE) begin
            dt_q = val;
        end else begin
            order_q    = val[ORDER_W-1:0];
            sweeps_q   = '0;
            gen_order  = val[ORDER_W-1:0];
            gen_sweeps = '0;
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (req_pend_q.size() != 0 || s_tvalid || pos_expect_q.size() != 0);
    endtask

    // driver: present queued requests, idle in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                pos_expect_q.push_back(integrate_elem(drv_req));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (req_pend_q.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 9);
                    s_tvalid <= 1'b0;
                end else if (req_pend_q.size() != 0) begin
                    drv_req = req_pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, drv_req.deriv, drv_req.pos, drv_req.idx};
                    s_tlast  <= drv_req.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result against the oldest prediction, stall in bursts
    always @(posedge aclk) begin
        elem_res_t want;
        logic [IDX_W-1:0]         got_idx;
        logic signed [DATA_W-1:0] got_pos;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_idx = m_tdata[IDX_W-1:0];
                got_pos = m_tdata[IDX_W +: DATA_W];
                if (pos_expect_q.size() == 0) begin
                    $error("unexpected result: elem_index_out %0d", got_idx);
                    fail_cnt++;
                end else begin
                    want = pos_expect_q.pop_front();
                    if (got_idx !== want.idx) begin
                        $error("elem_index_out: expected %0d, actual %0d", want.idx, got_idx);
                        fail_cnt++;
                    end
                    if (got_pos !== want.pos) begin
                        $error("position_out: expected %0d, actual %0d", want.pos, got_pos);
                        fail_cnt++;
                    end
                    if (m_tuser !== want.ovf) begin
                        $error("overflow: expected %0b, actual %0b", want.ovf, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tlast !== want.done) begin
                        $error("sweep_done: expected %0b, actual %0b", want.done, m_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [STEP_W-1:0]  step;
        logic [STEP_W-1:0]  ord_word;
        int                 rand_cnt;
        int                 n_sweeps;
        int                 len;
        int                 p;
        int                 idx;
        bit                 lastf;
        dt_q       = STEP_RESET;
        order_q    = ORDER_RESET;
        sweeps_q   = '0;
        gen_order  = ORDER_RESET;
        gen_sweeps = '0;
        last_idx   = 0;
        rand_cnt   = 0;
        elem_pool[0] = 0;
        elem_pool[1] = ELEM_COUNT - 1;
        for (int i = 2; i < POOL_SIZE; i++)
            elem_pool[i] = $urandom_range(0, ELEM_COUNT - 1);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values of dt and order, saturation both ways
        push_req(0, Q_MAX, Q_MAX, 1'b0);
        push_req(ELEM_COUNT - 1, Q_MIN, Q_MIN, 1'b1);
        wait_drained();

        // largest dt, order zero behaves as first order, truncation toward zero
        write_reg(REG_STEP_SIZE, 24'hFF_FFFF);
        write_reg(REG_METHOD_ORDER, 24'd0);
        push_req(1, 32'sd0, 32'sd1, 1'b0);
        push_req(2, -32'sd5, -32'sd1, 1'b0);
        push_req(3, Q_MIN, Q_MAX, 1'b1);
        push_req(1, Q_MAX, Q_MIN, 1'b1);
        wait_drained();

        // order seven behaves as six; ramp one element through every order,
        // then hold the sweep counter at its ceiling
        write_reg(REG_STEP_SIZE, 24'h01_0000);
        write_reg(REG_METHOD_ORDER, 24'd7);
        for (int k = 0; k < 8; k++)
            push_req(7, k * 1000, (k % 2) ? -(k + 1) * 65536 : (k + 1) * 65536, 1'b1);
        push_req(7, 32'sd0, 32'sd12345, 1'b0);
        wait_drained();

        // zero dt leaves the position alone
        write_reg(REG_STEP_SIZE, 24'd0);
        write_reg(REG_METHOD_ORDER, 24'd6);
        push_req(7, Q_MAX, Q_MAX, 1'b0);
        push_req(ELEM_COUNT - 1, Q_MIN, Q_MIN, 1'b1);

        while (rand_cnt < RAND_ITEMS) begin
            wait_drained();
            if (rand_cnt >= RAND_ITEMS * 7 / 8)
                quiet = 1'b1;
            case ($urandom_range(0, 4))
                0:       step = 24'd0;
                1:       step = 24'hFF_FFFF;
                2:       step = 24'h01_0000;
                3:       step = STEP_W'($urandom_range(0, 24'h03_FFFF));
                default: step = STEP_W'($urandom);
            endcase
            write_reg(REG_STEP_SIZE, step);
            if ($urandom_range(0, 3) != 0) begin
                ord_word = STEP_W'($urandom);
                if ($urandom_range(0, 7) == 0)
                    ord_word[ORDER_W-1:0] = $urandom_range(0, 1) ? 3'd7 : 3'd0;
                else
                    ord_word[ORDER_W-1:0] = ORDER_W'($urandom_range(1, 6));
                write_reg(REG_METHOD_ORDER, ord_word);
            end
            n_sweeps = $urandom_range(2, 12);
            for (int s = 0; s < n_sweeps; s++) begin
                len = $urandom_range(1, 16);
                for (int i = 0; i < len; i++) begin
                    p = clamp_order(gen_order, gen_sweeps);
                    if ($urandom_range(0, 7) == 0)
                        idx = $urandom_range(0, ELEM_COUNT - 1);
                    else
                        idx = elem_pool[$urandom_range(0, POOL_SIZE - 1)];
                    // never read history slots that were not yet written
                    if (gen_depth[idx] + 1 < p)
                        idx = last_idx;
                    lastf = (i == len - 1) &&
                            !(s == n_sweeps - 1 && $urandom_range(0, 3) == 0);
                    push_req(idx, rand_word(), rand_word(), lastf);
                    rand_cnt++;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
